// ===== design/bdq_pkg.sv =====
package bdq_pkg;

    // Field widths of the channels.
    localparam int OPC_W   = 2;
    localparam int WC_W    = 2;
    localparam int VAL_W   = 32;
    localparam int MOVED_W = 3;
    localparam int FILL_W  = 9;
    localparam int CAP_W   = 9;
    localparam int BYTE_W  = 8;

    // Opcodes.
    localparam logic [OPC_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OPC_W-1:0] OP_POP   = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OPC_W-1:0] OP_NOP   = 2'd3;

    // Width codes; the reserved code moves four bytes.
    localparam logic [WC_W-1:0] WC_1   = 2'd0;
    localparam logic [WC_W-1:0] WC_2   = 2'd1;
    localparam logic [WC_W-1:0] WC_4   = 2'd2;
    localparam logic [WC_W-1:0] WC_RSV = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_XFER,
        S_RESULT
    } t_state;

    // Request from the sequencer to the pointer unit.
    typedef struct packed {
        logic step;
        logic back;
        logic pop;
        logic clear;
    } t_ptr_cmd;

    // Status from the pointer unit.
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [FILL_W-1:0] count;
    } t_ptr_stat;

endpackage

// ===== design/bdq_item_if.sv =====
interface bdq_item_if;
    import bdq_pkg::*;

    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic             at_back;
    logic [WC_W-1:0]  width_code;
    logic [VAL_W-1:0] value_in;

    modport source (output valid, opcode, at_back, width_code, value_in, input ready);
    modport sink   (input valid, opcode, at_back, width_code, value_in, output ready);
endinterface

// ===== design/bdq_result_if.sv =====
interface bdq_result_if;
    import bdq_pkg::*;

    logic               valid;
    logic               ready;
    logic [VAL_W-1:0]   value_out;
    logic [MOVED_W-1:0] bytes_moved;
    logic [FILL_W-1:0]  fill_level;

    modport source (output valid, value_out, bytes_moved, fill_level, input ready);
    modport sink   (input valid, value_out, bytes_moved, fill_level, output ready);
endinterface

// ===== design/bdq_cfg_if.sv =====
interface bdq_cfg_if;
    import bdq_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity_in_use;

    modport source (output valid, capacity_in_use, input ready);
    modport sink   (input valid, capacity_in_use, output ready);
endinterface

// ===== design/byte_deque_multibyte_access_core.sv =====
// Channel   Dir  Payload                                   Handshake
// i_in      in   opcode, at_back, width_code, value_in     valid/ready
// o_out     out  value_out, bytes_moved, fill_level        valid/ready
// i_cfg     in   capacity_in_use                           valid/ready, always ready
//
// An item with n bytes (1, 2 or 4) is moved byte by byte and then passes the result
// stage; clear and no-op go straight to it. The single-port byte memory handles one byte per
// cycle, and a pop waits for the last registered read before its result is loaded.
// Reset clears head, count and the ring size to 256 (or DEPTH if smaller); the
// byte memory is not cleared. A stalled output holds its word while the next item
// is taken; that item waits in its result stage until the output is free.
module byte_deque_multibyte_access_core #(
    parameter int DEPTH = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bdq_item_if.sink     i_in,
    bdq_result_if.source o_out,
    bdq_cfg_if.sink      i_cfg
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_ptr_cmd          cmd;
    t_ptr_stat         stat;
    logic [AW-1:0]     slot;
    logic              mem_we, mem_re;
    logic [BYTE_W-1:0] mem_wdata, mem_rdata;

    // Configuration writes are taken at any time.
    assign i_cfg.ready = 1'b1;

    // Head, count and ring size.
    bdq_ptr #(.DEPTH(DEPTH)) u_ptr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_wr  (i_cfg.valid),
        .i_cfg_cap (i_cfg.capacity_in_use),
        .i_cmd     (cmd),
        .o_slot    (slot),
        .o_stat    (stat)
    );

    // Byte sequencer and output register.
    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    // Byte store.
    bdq_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_addr  (slot),
        .i_we    (mem_we),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .o_rdata (mem_rdata)
    );
endmodule

// ===== design/bdq_ram.sv =====
module bdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/bdq_ptr.sv =====
module bdq_ptr #(
    parameter int DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr,
    input  logic [bdq_pkg::CAP_W-1:0]     i_cfg_cap,
    input  bdq_pkg::t_ptr_cmd             i_cmd,
    output logic [$clog2(DEPTH)-1:0]      o_slot,
    output bdq_pkg::t_ptr_stat            o_stat
);
    import bdq_pkg::*;

    localparam int AW         = $clog2(DEPTH);
    localparam int SW         = $clog2(DEPTH + 1);
    localparam int CW         = (SW > CAP_W) ? SW : CAP_W;
    localparam int SUMW       = CW + 1;
    localparam int RESET_RING = (DEPTH < 256) ? DEPTH : 256;

    logic [AW-1:0]     r_head, n_head;
    logic [FILL_W-1:0] r_count, n_count;
    logic [SW-1:0]     r_ring, n_ring;

    logic [CW-1:0]   ring_c, count_c, head_c, off_c, ring_m1, head_inc_c, cap_c;
    logic [SUMW-1:0] sum, back_slot;
    logic [AW-1:0]   head_dec, head_inc;
    logic            full, empty;

    // Ring arithmetic: every index stays below the ring size, so one
    // compare and subtract wraps a sum.
    always_comb begin
        ring_c     = CW'(r_ring);
        count_c    = CW'(r_count);
        head_c     = CW'(r_head);
        full       = (count_c >= ring_c);
        empty      = (r_count == '0);
        off_c      = i_cmd.pop ? (count_c - CW'(1)) : count_c;
        sum        = SUMW'(head_c) + SUMW'(off_c);
        back_slot  = (sum >= SUMW'(ring_c)) ? (sum - SUMW'(ring_c)) : sum;
        ring_m1    = ring_c - CW'(1);
        head_dec   = (r_head == '0) ? ring_m1[AW-1:0] : (r_head - AW'(1));
        head_inc_c = head_c + CW'(1);
        head_inc   = (head_inc_c == ring_c) ? '0 : head_inc_c[AW-1:0];
    end

    // Slot of the byte touched this cycle.
    always_comb begin
        if (i_cmd.back) begin
            o_slot = back_slot[AW-1:0];
        end else if (i_cmd.pop) begin
            o_slot = r_head;
        end else begin
            o_slot = head_dec;
        end
    end

    assign o_stat.full  = full;
    assign o_stat.empty = empty;
    assign o_stat.count = r_count;

    // Next head, count and ring size.
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_ring  = r_ring;
        cap_c   = CW'(i_cfg_cap);
        if (i_cfg_wr) begin
            n_head  = '0;
            n_count = '0;
            if (cap_c == '0) begin
                n_ring = SW'(1);
            end else if (cap_c > CW'(DEPTH)) begin
                n_ring = SW'(DEPTH);
            end else begin
                n_ring = cap_c[SW-1:0];
            end
        end else if (i_cmd.clear) begin
            n_head  = '0;
            n_count = '0;
        end else if (i_cmd.step) begin
            if (i_cmd.pop) begin
                n_count = r_count - FILL_W'(1);
                if (!i_cmd.back) begin
                    n_head = head_inc;
                end
            end else begin
                n_count = r_count + FILL_W'(1);
                if (!i_cmd.back) begin
                    n_head = head_dec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_ring  <= SW'(RESET_RING);
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_ring  <= n_ring;
        end
    end

`ifndef SYNTH
    // The fill never exceeds the ring size.
    a_count_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_count) <= CW'(r_ring))
        else $error("byte count beyond ring size");

    // The head always points inside the ring.
    a_head_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_head) < CW'(r_ring))
        else $error("head index outside ring");
`endif
endmodule

// ===== design/bdq_ctrl.sv =====
module bdq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bdq_item_if.sink                   i_in,
    bdq_result_if.source               o_out,
    input  bdq_pkg::t_ptr_stat         i_stat,
    output bdq_pkg::t_ptr_cmd          o_cmd,
    output logic                       o_mem_we,
    output logic                       o_mem_re,
    output logic [bdq_pkg::BYTE_W-1:0] o_mem_wdata,
    input  logic [bdq_pkg::BYTE_W-1:0] i_mem_rdata
);
    import bdq_pkg::*;

    t_state             r_state, n_state;
    logic [OPC_W-1:0]   r_op;
    logic               r_back;
    logic [1:0]         r_last;
    logic [1:0]         r_k;
    logic [VAL_W-1:0]   r_val;
    logic [VAL_W-1:0]   r_acc;
    logic [MOVED_W-1:0] r_moved;
    logic               r_rd_vld;
    logic [1:0]         r_rd_pos;
    logic               r_out_vld;
    logic [VAL_W-1:0]   r_out_value;
    logic [MOVED_W-1:0] r_out_moved;
    logic [FILL_W-1:0]  r_out_fill;

    logic       accept, is_pop, step, load;
    logic [1:0] k_rev, pos, in_last;

    // Byte position within the word for the current step.
    always_comb begin
        is_pop = (r_op == OP_POP);
        k_rev  = r_last - r_k;
        pos    = (r_back ^ is_pop) ? k_rev : r_k;
    end

    // Index of the last byte of the incoming word.
    always_comb begin
        unique case (i_in.width_code) inside
            WC_1:         in_last = 2'd0;
            WC_2:         in_last = 2'd1;
            WC_4, WC_RSV: in_last = 2'd3;
            default:      in_last = 2'd3;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in.opcode == OP_PUSH || i_in.opcode == OP_POP)
                            ? S_XFER : S_RESULT;
                end
            end
            S_XFER: begin
                if (r_k == r_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: handshake, pointer requests and memory strobes.
    always_comb begin
        i_in.ready  = (r_state == S_IDLE);
        accept      = i_in.valid && (r_state == S_IDLE);
        step        = (r_state == S_XFER) && (is_pop ? !i_stat.empty : !i_stat.full);
        load        = (r_state == S_RESULT) && !r_rd_vld && (!r_out_vld || o_out.ready);
        o_cmd.step  = step;
        o_cmd.back  = r_back;
        o_cmd.pop   = is_pop;
        o_cmd.clear = accept && (i_in.opcode == OP_CLEAR);
        o_mem_we    = step && !is_pop;
        o_mem_re    = step && is_pop;
        o_mem_wdata = r_val[{pos, 3'b000} +: BYTE_W];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= o_mem_re;
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Word registers: latch the item, count bytes, merge read data.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_in.opcode;
            r_back  <= i_in.at_back;
            r_last  <= in_last;
            r_val   <= i_in.value_in;
            r_k     <= 2'd0;
            r_moved <= '0;
        end else if (r_state == S_XFER) begin
            r_k <= r_k + 2'd1;
            if (step) begin
                r_moved <= r_moved + MOVED_W'(1);
            end
        end
        r_rd_pos <= pos;
        if (accept) begin
            r_acc <= '0;
        end else if (r_rd_vld) begin
            r_acc[{r_rd_pos, 3'b000} +: BYTE_W] <= i_mem_rdata;
        end
        if (load) begin
            r_out_value <= r_acc;
            r_out_moved <= r_moved;
            r_out_fill  <= i_stat.count;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.value_out   = r_out_value;
    assign o_out.bytes_moved = r_out_moved;
    assign o_out.fill_level  = r_out_fill;

`ifndef SYNTH
    // Read data only returns for a read issued during a transfer.
    a_read_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state) == S_XFER)
        else $error("read return without a transfer step");

    // No item moves more bytes than its width.
    a_moved_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) |-> (r_moved <= ({1'b0, r_last} + 3'd1)))
        else $error("more bytes moved than the width allows");
`endif
endmodule

// ===== sim/byte_deque_multibyte_access_core_tb.sv =====
`timescale 1ns / 100ps

module byte_deque_multibyte_access_core_tb;
    import bdq_pkg::*;

    localparam int RING_DEPTH = 256;
    // Worst item is a four-byte pop: its byte transfers, the final read and the result stage all
    // lie between acceptance and the next ready.
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_WORDS = 830;
    localparam int N_DIRECTED = 26;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // One stimulus row; for a capacity write the value field holds the capacity.
    typedef struct packed {
        t_row_kind          kind;
        logic [OPC_W-1:0]   op;
        logic               back;
        logic [WC_W-1:0]    wc;
        logic [VAL_W-1:0]   value;
        logic               typed;
        logic [VAL_W-1:0]   want_value;
        logic [MOVED_W-1:0] want_moved;
        logic [FILL_W-1:0]  want_fill;
    } t_row;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [MOVED_W-1:0] moved;
        logic [FILL_W-1:0]  fill;
    } t_deque_word;

    logic clk = 1'b0;
    logic rst_n;

    bdq_item_if   in_if ();
    bdq_result_if out_if ();
    bdq_cfg_if    cfg_if ();

    byte_deque_multibyte_access_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Shadow copy of the deque.
    logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
    logic [CAP_W-1:0]  ring_cap;
    int unsigned       ring_head;
    int unsigned       ring_count;

    t_deque_word expected_words [$];
    t_row        dir_tab [N_DIRECTED];
    int          mismatches = 0;
    int          words_sent = 0;
    bit          calm = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one item to the shadow deque and return the word it should produce.
    function automatic t_deque_word deque_apply(input logic [OPC_W-1:0] op, input logic back,
                                                input logic [WC_W-1:0] wc,
                                                input logic [VAL_W-1:0] value);
        t_deque_word w;
        int unsigned rs;
        int unsigned n;
        int unsigned pos;
        int unsigned slot;
        w = '0;
        rs = (ring_cap == 0) ? 1 : ((ring_cap > RING_DEPTH) ? RING_DEPTH : ring_cap);
        n = wc[1] ? 4 : (wc[0] ? 2 : 1);
        if (op == OP_PUSH) begin
            for (int k = 0; k < n; k++) begin
                // The back end takes the high byte first, the front end the low byte.
                pos = back ? (n - 1 - k) : k;
                if (ring_count < rs) begin
                    if (back) begin
                        slot = (ring_head + ring_count) % rs;
                    end else begin
                        ring_head = (ring_head == 0) ? rs - 1 : ring_head - 1;
                        slot = ring_head;
                    end
                    ring_bytes[slot] = value[8*pos +: 8];
                    ring_count++;
                    w.moved++;
                end
            end
        end else if (op == OP_POP) begin
            for (int k = 0; k < n; k++) begin
                // The front end yields the high byte first, the back end the low byte.
                pos = back ? k : (n - 1 - k);
                if (ring_count > 0) begin
                    if (back) begin
                        slot = (ring_head + ring_count - 1) % rs;
                    end else begin
                        slot = ring_head;
                        ring_head = (ring_head + 1) % rs;
                    end
                    w.value[8*pos +: 8] = ring_bytes[slot];
                    ring_count--;
                    w.moved++;
                end
            end
        end else if (op == OP_CLEAR) begin
            ring_head = 0;
            ring_count = 0;
        end
        w.fill = ring_count[FILL_W-1:0];
        return w;
    endfunction

    // Mostly short idle gaps, a few long ones, none in a calm stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Hold the sender back until every expected word has come, then let the block settle.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the ring capacity while the block is idle; the write also empties the deque.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.capacity_in_use <= cap;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        ring_cap = cap;
        ring_head = 0;
        ring_count = 0;
    endtask

    // Offer one item; valid stays high after acceptance so back-to-back words need no toggle.
    task automatic send_word(input t_row row);
        int gap;
        t_deque_word w;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.opcode <= row.op;
        in_if.at_back <= row.back;
        in_if.width_code <= row.wc;
        in_if.value_in <= row.value;
        in_if.valid <= 1'b1;
        do @(posedge clk); while (!in_if.ready);
        w = deque_apply(row.op, row.back, row.wc, row.value);
        if (row.typed) begin
            w = '{row.want_value, row.want_moved, row.want_fill};
        end
        expected_words.push_back(w);
        words_sent++;
    endtask

    // Output side: runs of ready broken by stalls, mostly short and a few long.
    initial begin : result_sink
        int run;
        int stall;
        out_if.ready = 1'b0;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
            out_if.ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Compare each accepted word with the oldest expectation.
    always @(posedge clk) begin : check_words
        t_deque_word w;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_words.size() == 0) begin
                $error("result word arrived with nothing expected");
                mismatches++;
            end else begin
                w = expected_words.pop_front();
                if (out_if.value_out !== w.value) begin
                    $error("value_out: expected %h, got %h", w.value, out_if.value_out);
                    mismatches++;
                end
                if (out_if.bytes_moved !== w.moved) begin
                    $error("bytes_moved: expected %0d, got %0d", w.moved, out_if.bytes_moved);
                    mismatches++;
                end
                if (out_if.fill_level !== w.fill) begin
                    $error("fill_level: expected %0d, got %0d", w.fill, out_if.fill_level);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row row;
        int len;
        int push_pct;
        int r;
        in_if.valid = 1'b0;
        in_if.opcode = OP_NOP;
        in_if.at_back = 1'b0;
        in_if.width_code = WC_1;
        in_if.value_in = '0;
        cfg_if.valid = 1'b0;
        cfg_if.capacity_in_use = '0;
        rst_n = 1'b0;
        ring_cap = 9'd256;
        ring_head = 0;
        ring_count = 0;

        // Empty pops, partial pops, reserved codes, capacity extremes and saturation.
        dir_tab = '{
            '{ROW_ITEM, OP_POP,   1'b0, WC_4,   32'h0,        1'b1, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_POP,   1'b1, WC_1,   32'h0,        1'b1, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_PUSH,  1'b1, WC_4,   32'hFFFFFFFF, 1'b1, 32'h0, 3'd4, 9'd4},
            '{ROW_ITEM, OP_PUSH,  1'b0, WC_2,   32'h0000A5C3, 1'b1, 32'h0, 3'd2, 9'd6},
            '{ROW_ITEM, OP_PUSH,  1'b1, WC_1,   32'h00000000, 1'b1, 32'h0, 3'd1, 9'd7},
            '{ROW_ITEM, OP_NOP,   1'b1, WC_RSV, 32'hFFFFFFFF, 1'b1, 32'h0, 3'd0, 9'd7},
            '{ROW_ITEM, OP_POP,   1'b0, WC_4,   32'h0,        1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_POP,   1'b1, WC_2,   32'h0,        1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_POP,   1'b0, WC_RSV, 32'h0,        1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_PUSH,  1'b1, WC_RSV, 32'h12345678, 1'b1, 32'h0, 3'd4, 9'd4},
            '{ROW_ITEM, OP_CLEAR, 1'b0, WC_1,   32'hFFFFFFFF, 1'b1, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_PUSH,  1'b0, WC_4,   32'h80000001, 1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_PUSH,  1'b1, WC_2,   32'hFFFF7E01, 1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_POP,   1'b1, WC_4,   32'h0,        1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_POP,   1'b0, WC_4,   32'h0,        1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_CFG,  OP_NOP,   1'b0, WC_1,   32'd1,        1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_PUSH,  1'b1, WC_4,   32'h89ABCDEF, 1'b1, 32'h0, 3'd1, 9'd1},
            '{ROW_ITEM, OP_PUSH,  1'b0, WC_1,   32'h00000055, 1'b1, 32'h0, 3'd0, 9'd1},
            '{ROW_ITEM, OP_POP,   1'b1, WC_4,   32'h0,        1'b1, 32'h89, 3'd1, 9'd0},
            '{ROW_CFG,  OP_NOP,   1'b0, WC_1,   32'd0,        1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_PUSH,  1'b0, WC_2,   32'hAAAA0102, 1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_CFG,  OP_NOP,   1'b0, WC_1,   32'd511,      1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_PUSH,  1'b0, WC_4,   32'hDEADBEEF, 1'b1, 32'h0, 3'd4, 9'd4},
            '{ROW_ITEM, OP_POP,   1'b0, WC_4,   32'h0,   1'b1, 32'hDEADBEEF, 3'd4, 9'd0},
            '{ROW_CFG,  OP_NOP,   1'b0, WC_1,   32'd256,      1'b0, 32'h0, 3'd0, 9'd0},
            '{ROW_ITEM, OP_POP,   1'b0, WC_1,   32'h0,        1'b1, 32'h0, 3'd0, 9'd0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                write_capacity(dir_tab[i].value[CAP_W-1:0]);
            end else begin
                send_word(dir_tab[i]);
            end
        end

        // Random phases, each at its own ring size and push/pop balance.
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0: write_capacity(9'd1);
                1: write_capacity(9'd2);
                2: write_capacity(9'd3);
                3: write_capacity(CAP_W'($urandom_range(4, 8)));
                4: write_capacity(9'd0);
                5: write_capacity(CAP_W'($urandom_range(257, 511)));
                6: write_capacity(9'd256);
                7: write_capacity(9'd255);
                default: write_capacity(CAP_W'($urandom_range(1, 256)));
            endcase
            len = $urandom_range(20, 130);
            case ($urandom_range(0, 3))
                0: push_pct = 25;
                1: push_pct = 50;
                2: push_pct = 75;
                default: push_pct = 92;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len && words_sent < RANDOM_WORDS; k++) begin
                r = $urandom_range(0, 99);
                row = '0;
                row.kind = ROW_ITEM;
                if (r < 2) begin
                    row.op = OP_NOP;
                end else if (r < 5) begin
                    row.op = OP_CLEAR;
                end else if (r < 5 + (push_pct * 95) / 100) begin
                    row.op = OP_PUSH;
                end else begin
                    row.op = OP_POP;
                end
                row.back = 1'($urandom_range(0, 1));
                row.wc = WC_W'($urandom_range(0, 3));
                row.value = $urandom();
                send_word(row);
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("** byte_deque_multibyte_access_core: PASSED **");
        end else begin
            $display("** byte_deque_multibyte_access_core: FAILED **");
        end
        $finish;
    end

    // Run limit, several times the slowest legal run.
    initial begin : watchdog
        #(6_000_000);
        $display("** byte_deque_multibyte_access_core: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bdq_pkg.sv
design/bdq_item_if.sv
design/bdq_result_if.sv
design/bdq_cfg_if.sv
design/bdq_ram.sv
design/bdq_ptr.sv
design/bdq_ctrl.sv
design/byte_deque_multibyte_access_core.sv
sim/byte_deque_multibyte_access_core_tb.sv
